// ----- hdl/kect_pkg.sv -----
package kect_pkg;

  // field widths of the event and result words
  localparam int SVC_W      = 16;
  localparam int MSG_W      = 8;
  localparam int CNT_W      = 32;
  localparam int SWORD_W    = 64;
  localparam int MWORD_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int MSG_LSB    = 24;
  localparam int ENTRY_W    = SVC_W + MSG_W + CNT_W;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_COUNTED = 3'd0,
    ST_NEW     = 3'd1,
    ST_FULL    = 3'd2,
    ST_INVALID = 3'd3,
    ST_DRAINED = 3'd4
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_DRAIN_RD,
    S_DRAIN_OUT
  } fsm_t;

  // one table slot as held in the memory
  typedef struct packed {
    logic [SVC_W-1:0] service;
    logic [MSG_W-1:0] msg;
    logic [CNT_W-1:0] count;
  } entry_t;

  // one result word
  typedef struct packed {
    status_t          status;
    logic [SVC_W-1:0] service;
    logic [MSG_W-1:0] msg;
    logic [CNT_W-1:0] count;
    logic             last;
  } res_t;

endpackage

// ----- hdl/keyed_event_counter_table_core.sv -----
// keyed event counter table
// input channel (in_valid/in_stall) takes one word at a time: in_mode 0 records
// an event keyed by service id (in_service_word[15:0]) and message id
// (in_msg_word[31:24]); in_mode 1 drains the table.
// result channel (out_valid/out_stall) gives one word per event, or
// TABLE_DEPTH words per drain in slot order with out_last on the final one.
// slots live in one synchronous memory; occupied slots always form
// a prefix of the table, tracked by a fill count.
// record: the scan reads one slot per cycle until a match or the end of the
// occupied slots; an event of invalid format skips the scan.
// drain: after a first slot read, one slot per cycle while out_stall does not
// hold the output register; the table is empty once the last word has been loaded.
// in_stall stays high until the current word's results are all in the output
// register; the output register holds its word while out_stall is high and
// the drain pauses with it.
// reset: synchronous, empties the table at once by clearing the fill count.
module keyed_event_counter_table_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [63:0] in_service_word,
  input  logic [31:0] in_msg_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_entry_service,
  output logic [7:0]  out_entry_msg,
  output logic [31:0] out_entry_count,
  output logic        out_last
);

  import kect_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  fsm_t             state_r, state_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]    drn_idx_r, drn_idx_nxt;
  logic [SVC_W-1:0] svc_r, svc_nxt;
  logic [MSG_W-1:0] msg_r, msg_nxt;
  res_t             res_r, res_nxt;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  logic             ld_valid, ld_ready;
  res_t             ld_res, out_res;

  logic             in_acc;
  logic [SVC_W-1:0] in_svc;
  logic [MSG_W-1:0] in_msg;
  logic             in_bad;
  logic             more;
  logic             hit;
  logic             drain_last;
  logic             drain_live;
  res_t             drain_res;

  // slot memory
  kect_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata_raw)
  );

  assign ram_rdata = entry_t'(rdata_raw);

  // result register
  kect_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (ld_valid),
    .ld_res    (ld_res),
    .ld_ready  (ld_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_entry_service = out_res.service;
  assign out_entry_msg     = out_res.msg;
  assign out_entry_count   = out_res.count;
  assign out_last          = out_res.last;

  // input decode
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_svc   = in_service_word[SVC_W-1:0];
  assign in_msg   = in_msg_word[MSG_LSB +: MSG_W];
  assign in_bad   = (|in_service_word[SWORD_W-1:SVC_W]) || (in_msg == '0);

  // scan compare against the slot read last cycle
  assign more = (idx_r < fill_r);
  assign hit  = rd_pend_r && (ram_rdata.service == svc_r) && (ram_rdata.msg == msg_r);

  // drain word for the slot currently on the read port
  assign drain_last = (drn_idx_r == AW'(TABLE_DEPTH - 1));
  assign drain_live = (CW'(drn_idx_r) < fill_r);
  always_comb begin
    drain_res.status  = ST_DRAINED;
    drain_res.service = drain_live ? ram_rdata.service : '0;
    drain_res.msg     = drain_live ? ram_rdata.msg : '0;
    drain_res.count   = drain_live ? ram_rdata.count : '0;
    drain_res.last    = drain_last;
  end

  // next state and datapath control
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    rd_pend_nxt = 1'b0;
    rd_idx_nxt  = rd_idx_r;
    drn_idx_nxt = drn_idx_r;
    svc_nxt     = svc_r;
    msg_nxt     = msg_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = rd_idx_r;
    ram_wdata   = '{service: svc_r, msg: msg_r, count: '0};
    ram_re      = 1'b0;
    ram_raddr   = idx_r[AW-1:0];
    ld_valid    = 1'b0;
    ld_res      = res_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          svc_nxt = in_svc;
          msg_nxt = in_msg;
          idx_nxt = '0;
          if (in_mode) begin
            drn_idx_nxt = '0;
            state_nxt   = S_DRAIN_RD;
          end else if (in_bad) begin
            res_nxt   = '{status: ST_INVALID, service: in_svc, msg: in_msg,
                          count: '0, last: 1'b1};
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          // key found, bump its count
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r;
          ram_wdata = '{service: svc_r, msg: msg_r, count: ram_rdata.count + 1'b1};
          res_nxt   = '{status: ST_COUNTED, service: svc_r, msg: msg_r,
                        count: ram_rdata.count + 1'b1, last: 1'b1};
          state_nxt = S_EMIT;
        end else if (more) begin
          // issue the next slot read
          ram_re      = 1'b1;
          ram_raddr   = idx_r[AW-1:0];
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = idx_r[AW-1:0];
          idx_nxt     = idx_r + 1'b1;
        end else if (!rd_pend_r) begin
          // every occupied slot checked
          if (fill_r < CW'(TABLE_DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = fill_r[AW-1:0];
            ram_wdata = '{service: svc_r, msg: msg_r, count: CNT_W'(1)};
            fill_nxt  = fill_r + 1'b1;
            res_nxt   = '{status: ST_NEW, service: svc_r, msg: msg_r,
                          count: CNT_W'(1), last: 1'b1};
          end else begin
            res_nxt   = '{status: ST_FULL, service: svc_r, msg: msg_r,
                          count: '0, last: 1'b1};
          end
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        ld_valid = 1'b1;
        ld_res   = res_r;
        if (ld_ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_DRAIN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = drn_idx_r;
        state_nxt = S_DRAIN_OUT;
      end

      S_DRAIN_OUT: begin
        ld_valid = 1'b1;
        ld_res   = drain_res;
        if (ld_ready) begin
          if (drain_last) begin
            fill_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            // overlap the next slot read with this load
            ram_re      = 1'b1;
            ram_raddr   = drn_idx_r + 1'b1;
            drn_idx_nxt = drn_idx_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    rd_idx_r  <= rd_idx_nxt;
    drn_idx_r <= drn_idx_nxt;
    svc_r     <= svc_nxt;
    msg_r     <= msg_nxt;
    res_r     <= res_nxt;
  end

`ifndef SYNTHESIS
  // fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table size");

  // fill count grows by one slot at a time or drops to empty
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |-> ((fill_r == $past(fill_r) + 1'b1) || (fill_r == '0)))
    else $error("fill count jumped");

  // memory is written only while scanning
  a_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN))
    else $error("slot write outside scan");

  // the final drain word leaves the table empty
  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN_OUT && ld_ready && drain_last) |=> (fill_r == '0))
    else $error("table not empty after drain");

  // only drain words come without the last mark
  a_nonlast_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_DRAINED))
    else $error("non-final word outside a drain");
`endif

endmodule

// ----- hdl/kect_ram.sv -----
module kect_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/kect_out_stage.sv -----
module kect_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ld_valid,
  input  kect_pkg::res_t ld_res,
  output logic           ld_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output kect_pkg::res_t out_res
);

  import kect_pkg::*;

  logic out_valid_r;
  res_t out_res_r;

  // register is free when empty or when its word leaves this cycle
  assign ld_ready = !out_valid_r || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_ready) begin
      out_valid_r <= ld_valid;
    end
  end

  // payload, held while stalled
  always_ff @(posedge clk) begin
    if (ld_ready && ld_valid) begin
      out_res_r <= ld_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ----- test/kect_checker.sv -----
module kect_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_mode,
  input  logic [63:0] in_service_word,
  input  logic [31:0] in_msg_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_entry_service,
  input  logic [7:0]  out_entry_msg,
  input  logic [31:0] out_entry_count,
  input  logic        out_last,
  output int          fails,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import kect_pkg::*;

  // shadow copy of the counter table
  logic [SVC_W-1:0] shadow_svc [TABLE_DEPTH];
  logic [MSG_W-1:0] shadow_msg [TABLE_DEPTH];
  logic [CNT_W-1:0] shadow_cnt [TABLE_DEPTH];

  // words still owed by the block, oldest first
  res_t owed_words [$];

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fails++;
  endtask

  task automatic push_word(input status_t st, input logic [SVC_W-1:0] svc,
                           input logic [MSG_W-1:0] mid, input logic [CNT_W-1:0] cnt,
                           input logic lst);
    res_t w;
    w.status  = st;
    w.service = svc;
    w.msg     = mid;
    w.count   = cnt;
    w.last    = lst;
    owed_words.push_back(w);
  endtask

  // work out the words one accepted request causes, and update the shadow table
  task automatic count_event(input logic drain, input logic [SWORD_W-1:0] sw,
                             input logic [MWORD_W-1:0] mw);
    logic [SVC_W-1:0] svc;
    logic [MSG_W-1:0] mid;
    bit               placed;
    svc    = sw[SVC_W-1:0];
    mid    = mw[MWORD_W-1:MSG_LSB];
    placed = 1'b0;
    if (drain) begin
      // every slot in order, empty ones too, then the table is cleared
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        push_word(ST_DRAINED, shadow_svc[i], shadow_msg[i], shadow_cnt[i],
                  i == TABLE_DEPTH - 1);
        shadow_svc[i] = '0;
        shadow_msg[i] = '0;
        shadow_cnt[i] = '0;
      end
    end else if (sw[SWORD_W-1:SVC_W] != '0 || mid == '0) begin
      push_word(ST_INVALID, svc, mid, '0, 1'b1);
    end else begin
      // first matching key wins, else the first empty slot
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!placed) begin
          if (shadow_svc[i] == svc && shadow_msg[i] == mid) begin
            shadow_cnt[i] = shadow_cnt[i] + 1'b1;
            push_word(ST_COUNTED, svc, mid, shadow_cnt[i], 1'b1);
            placed = 1'b1;
          end else if (shadow_svc[i] == '0 && shadow_msg[i] == '0) begin
            shadow_svc[i] = svc;
            shadow_msg[i] = mid;
            shadow_cnt[i] = 1;
            push_word(ST_NEW, svc, mid, 1, 1'b1);
            placed = 1'b1;
          end
        end
      end
      if (!placed) push_word(ST_FULL, svc, mid, '0, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      owed_words.delete();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        shadow_svc[i] = '0;
        shadow_msg[i] = '0;
        shadow_cnt[i] = '0;
      end
      fails = 0;
    end else begin
      // request word taken by the block
      if (in_valid === 1'b1 && in_stall === 1'b0)
        count_event(in_mode, in_service_word, in_msg_word);
      // result word taken from the block
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (owed_words.size() == 0) begin
          report_mismatch("unexpected word, status", out_status, 0);
        end else begin
          want = owed_words.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_entry_service !== want.service)
            report_mismatch("entry_service", out_entry_service, want.service);
          if (out_entry_msg !== want.msg)
            report_mismatch("entry_msg", out_entry_msg, want.msg);
          if (out_entry_count !== want.count)
            report_mismatch("entry_count", out_entry_count, want.count);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
        end
      end
    end
    outstanding = owed_words.size();
  end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   TABLE_DEPTH  = 32;
  localparam int   RANDOM_WORDS = 130;
  localparam int   QUIET_WORDS  = 20;
  localparam int   LONG_HOLD    = 60;
  localparam int   POOL_SIZE    = 6;
  localparam logic MODE_RECORD  = 1'b0;
  localparam logic MODE_DRAIN   = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [63:0] in_service_word;
  logic [31:0] in_msg_word;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [15:0] out_entry_service;
  logic [7:0]  out_entry_msg;
  logic [31:0] out_entry_count;
  logic        out_last;

  int fails;
  int outstanding;
  int sent;
  bit quiet;
  bit calm;
  bit long_hold_req;

  // keys reused often so counts climb
  logic [23:0] key_pool [POOL_SIZE];

  keyed_event_counter_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_service_word  (in_service_word),
    .in_msg_word      (in_msg_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_entry_service(out_entry_service),
    .out_entry_msg    (out_entry_msg),
    .out_entry_count  (out_entry_count),
    .out_last         (out_last)
  );

  kect_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_service_word  (in_service_word),
    .in_msg_word      (in_msg_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_entry_service(out_entry_service),
    .out_entry_msg    (out_entry_msg),
    .out_entry_count  (out_entry_count),
    .out_last         (out_last),
    .fails            (fails),
    .outstanding      (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // offer one request word, with an occasional gap first; valid stays high after
  task automatic send_word(input logic m, input logic [63:0] sw, input logic [31:0] mw);
    int gap;
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= m;
    in_service_word <= sw;
    in_msg_word     <= mw;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent++;
  endtask

  // record event for a key, junk in the ignored message bits
  task automatic send_event(input logic [15:0] svc, input logic [7:0] mid);
    send_word(MODE_RECORD, {48'h0, svc}, {mid, 24'($urandom)});
  endtask

  task automatic send_drain();
    send_word(MODE_DRAIN, {$urandom, $urandom}, $urandom);
  endtask

  // malformed event: upper service bits set, or a zero message id, or both
  task automatic send_bad_event();
    logic [63:0] sw;
    logic [31:0] mw;
    sw = {$urandom, $urandom};
    mw = $urandom;
    case ($urandom_range(0, 2))
      0: if (sw[63:16] == '0) sw[$urandom_range(16, 63)] = 1'b1;
      1: begin
        sw[63:16] = '0;
        mw[31:24] = '0;
      end
      default: mw[31:24] = '0;
    endcase
    send_word(MODE_RECORD, sw, mw);
  endtask

  // stop offering and let every owed word come out
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  // fill the table with fresh keys past its depth, hit a held key, then drain
  task automatic fill_and_drain();
    logic [15:0] first_svc;
    first_svc = 16'($urandom);
    for (int k = 0; k < TABLE_DEPTH + 4; k++)
      send_event(k == 0 ? first_svc : 16'($urandom), 8'(k + 1));
    send_event(first_svc, 8'd1);
    send_drain();
  endtask

  // result side: random stall bursts, and one long hold when asked
  initial begin
    int burst;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // request side and verdict
  initial begin
    int fills;
    logic [23:0] key;
    in_valid        <= 1'b0;
    in_mode         <= MODE_RECORD;
    in_service_word <= '0;
    in_msg_word     <= '0;
    rst_n           <= 1'b0;
    quiet         = 1'b0;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    sent          = 0;
    fills         = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: drain of an empty table
    send_drain();
    // malformed events
    send_word(MODE_RECORD, 64'h0000_0000_0001_0000, 32'h0100_0000);
    send_word(MODE_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_word(MODE_RECORD, 64'h8000_0000_0000_1234, 32'h5A00_0000);
    send_word(MODE_RECORD, 64'h0000_0000_0000_FFFF, 32'h00FF_FFFF);
    send_word(MODE_RECORD, 64'h0, 32'h0);
    // new key at the top of both fields, then counted with other junk bits
    send_word(MODE_RECORD, 64'h0000_0000_0000_FFFF, 32'hFFFF_FFFF);
    send_word(MODE_RECORD, 64'h0000_0000_0000_FFFF, 32'hFF00_0000);
    // zero service id with the smallest message id
    send_word(MODE_RECORD, 64'h0, 32'h0100_0000);
    send_word(MODE_RECORD, 64'h0, 32'h01FF_FFFF);
    send_event(16'h0001, 8'h01);
    send_event(16'hFFFF, 8'hFF);
    send_event(16'h8000, 8'h80);
    // drain shows the entries, then the table starts empty again
    send_drain();
    send_event(16'hFFFF, 8'hFF);
    send_event(16'h0000, 8'h01);
    send_drain();
    wait_results_done();

    // random part
    foreach (key_pool[i]) key_pool[i] = {16'($urandom), 8'($urandom_range(1, 255))};

    // receiver holds off long while requests keep coming, so the block backs up
    long_hold_req = 1'b1;
    repeat (10) begin
      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_event(key[23:8], key[7:0]);
    end
    wait_results_done();
    fill_and_drain();
    fills++;

    while (sent < RANDOM_WORDS) begin
      calm  = ($urandom_range(0, 3) == 0);
      quiet = (sent >= RANDOM_WORDS - QUIET_WORDS);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(4, 10)) begin
            if ($urandom_range(0, 5) == 0)
              key = {16'($urandom), 8'($urandom_range(1, 255))};
            else
              key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_event(key[23:8], key[7:0]);
          end
        end
        5: repeat ($urandom_range(1, 3)) send_bad_event();
        6: send_drain();
        7: begin
          if (fills < 2) begin
            fill_and_drain();
            fills++;
          end else begin
            key_pool[$urandom_range(0, POOL_SIZE - 1)] =
              {16'($urandom), 8'($urandom_range(1, 255))};
          end
        end
        default: wait_results_done();
      endcase
    end

    quiet = 1'b1;
    wait_results_done();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
